// ===== sv/lvs_pkg.sv =====
// Shared constants and types for the variance-of-Laplacian sharpness core.
// No dependencies; imported by lvs_var_unit and laplacian_variance_sharpness_core.
package lvs_pkg;
   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int ColBits   = $clog2(MaxWidth);
   localparam int DimBits   = 13;
   localparam int GrayBits  = 18;
   localparam int LapBits   = 23;
   localparam int SqBits    = 44;
   localparam int SumBits   = 46;
   localparam int SqSumBits = 64;
   localparam int CountBits = 24;
   localparam int VarBits   = 40;
   localparam int DenBits   = 2 * CountBits;
   localparam int NumBits   = 128;

   localparam logic [DimBits-1:0] WidthReset  = 13'd640;
   localparam logic [DimBits-1:0] HeightReset = 13'd480;
   localparam logic [DimBits-1:0] DimMin      = 13'd3;
   localparam logic [DimBits-1:0] WidthMax    = 13'(MaxWidth);
   localparam logic [DimBits-1:0] HeightMax   = 13'(MaxHeight);

   localparam logic CsrWidth  = 1'b0;
   localparam logic CsrHeight = 1'b1;

   typedef struct packed {
      logic [CountBits-1:0]        count;
      logic signed [SumBits-1:0]   sum;
      logic [SqSumBits-1:0]        sq_sum;
   } lvs_frame_type;

   function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v,
                                                    input logic [DimBits-1:0] hi);
      logic [DimBits-1:0] r;
      r = v;
      if (v < DimMin) r = DimMin;
      if (v > hi) r = hi;
      return r;
   endfunction
endpackage

// ===== sv/lvs_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module lvs_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/lvs_var_unit.sv =====
// End-of-frame variance unit: serial multiplies and a restoring divider.
// Depends on lvs_pkg.
module lvs_var_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  lvs_pkg::lvs_frame_type        frame,
   output logic                          ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata
);
   import lvs_pkg::*;

   typedef enum logic [2:0] {U_IDLE, U_M1, U_M2, U_M3, U_DIV, U_OUT} ustate_type;

   ustate_type            state_ff;
   logic [NumBits-1:0]    mcand_ff;
   logic [SumBits-1:0]    mplier_ff;
   logic [NumBits-1:0]    acc_ff, p1_ff, num_ff;
   logic [7:0]            cnt_ff;
   logic [DenBits-1:0]    den_ff, rem_ff;
   logic [VarBits-1:0]    q_ff;
   logic [CountBits-1:0]  n_ff;
   logic [SumBits-1:0]    mag_ff;

   logic [NumBits-1:0]    acc_in;
   logic [DenBits:0]      trial;
   logic [SumBits-1:0]    mag;

   assign mag    = frame.sum[SumBits-1] ? SumBits'(-frame.sum) : frame.sum;
   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign trial  = {rem_ff, num_ff[NumBits-1]};
   assign ready  = (state_ff == U_IDLE);
   assign rsp_tvalid = (state_ff == U_OUT);
   assign rsp_tdata  = {n_ff, q_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         case (state_ff)
            U_IDLE: if (start) begin
               n_ff      <= frame.count;
               mag_ff    <= mag;
               mcand_ff  <= NumBits'(frame.sq_sum);
               mplier_ff <= SumBits'(frame.count);
               acc_ff    <= '0;
               cnt_ff    <= 8'(CountBits - 1);
               state_ff  <= U_M1;
            end
            U_M1, U_M2, U_M3: begin
               acc_ff    <= acc_in;
               mcand_ff  <= {mcand_ff[NumBits-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[SumBits-1:1]};
               cnt_ff    <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd0) begin
                  acc_ff <= '0;
                  case (state_ff)
                     U_M1: begin
                        p1_ff     <= acc_in;
                        mcand_ff  <= NumBits'(mag_ff);
                        mplier_ff <= mag_ff;
                        cnt_ff    <= 8'(SumBits - 1);
                        state_ff  <= U_M2;
                     end
                     U_M2: begin
                        num_ff    <= p1_ff - acc_in;
                        mcand_ff  <= NumBits'(n_ff);
                        mplier_ff <= SumBits'(n_ff);
                        cnt_ff    <= 8'(CountBits - 1);
                        state_ff  <= U_M3;
                     end
                     default: begin
                        den_ff   <= acc_in[DenBits-1:0];
                        rem_ff   <= '0;
                        cnt_ff   <= 8'(NumBits - 1);
                        state_ff <= U_DIV;
                     end
                  endcase
               end
            end
            U_DIV: begin
               num_ff <= {num_ff[NumBits-2:0], 1'b0};
               if (trial >= {1'b0, den_ff}) begin
                  rem_ff <= DenBits'(trial - {1'b0, den_ff});
                  q_ff   <= {q_ff[VarBits-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[DenBits-1:0];
                  q_ff   <= {q_ff[VarBits-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd0) state_ff <= U_OUT;
            end
            U_OUT: if (rsp_tready) state_ff <= U_IDLE;
            default: state_ff <= U_IDLE;
         endcase
      end
   end
endmodule

// ===== sv/laplacian_variance_sharpness_core.sv =====
// Variance-of-Laplacian focus measure over a streamed RGB frame.
// Per pixel: read line memories, form Laplacian, square, accumulate, each in its own state.
// A new pixel is accepted only after the previous one has been accumulated.
// A result is computed after a frame's last pixel by serial multiplies and a
// 128-step divider; a frame end stalls while the previous result is still in flight.
// Reset is synchronous; line memories are not cleared, and unwritten contents feed only border pixels, not accumulated.
module laplacian_variance_sharpness_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red, green, blue
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // laplacian_variance, interior_count
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [lvs_pkg::DimBits-1:0]   csr_wr_data
);
   import lvs_pkg::*;

   typedef enum logic [1:0] {P_IDLE, P_READ, P_SQ, P_ACC} pstate_type;

   pstate_type                 state_ff;
   logic [DimBits-1:0]         width_ff, height_ff;
   logic [ColBits-1:0]         col_ff, row_ff;
   logic [GrayBits-1:0]        g_ff;
   logic [GrayBits-1:0]        w_ff [6];
   logic signed [LapBits-1:0]  lap_ff;
   logic [SqBits-1:0]          sq_ff;
   logic                       inner_ff;
   logic signed [SumBits-1:0]  sum_ff;
   logic [SqSumBits-1:0]       sqsum_ff;
   logic [CountBits-1:0]       count_ff;

   logic [GrayBits-1:0]        above_rd, two_rd;
   logic                       mem_wr;
   logic [GrayBits-1:0]        g_in;
   logic signed [LapBits-1:0]  lap_in;
   logic signed [2*LapBits-1:0] sq_full;
   logic                       row_end, frame_end;
   logic                       unit_ready, unit_start;
   lvs_frame_type              frame_in;

   assign req_tready = (state_ff == P_IDLE);
   assign mem_wr     = (state_ff == P_READ);
   assign g_in = GrayBits'(10'd299) * GrayBits'(req_tdata[7:0])
               + GrayBits'(10'd587) * GrayBits'(req_tdata[15:8])
               + GrayBits'(10'd114) * GrayBits'(req_tdata[23:16]);
   assign lap_in = LapBits'(4 * $signed({1'b0, w_ff[2]}))
                 - LapBits'($signed({1'b0, w_ff[4]})) - LapBits'($signed({1'b0, w_ff[5]}))
                 - LapBits'($signed({1'b0, w_ff[1]})) - LapBits'($signed({1'b0, above_rd}));
   assign sq_full   = lap_ff * lap_ff;
   assign row_end   = ({1'b0, col_ff} + 13'd1) >= width_ff;
   assign frame_end = row_end && (({1'b0, row_ff} + 13'd1) >= height_ff);
   assign frame_in.count  = count_ff + CountBits'(inner_ff);
   assign frame_in.sum    = inner_ff ? sum_ff + SumBits'(lap_ff) : sum_ff;
   assign frame_in.sq_sum = inner_ff ? sqsum_ff + SqSumBits'(sq_ff) : sqsum_ff;
   assign unit_start = (state_ff == P_ACC) && frame_end && unit_ready;

   lvs_ram #(.WIDTH(GrayBits), .DEPTH(MaxWidth)) u_above (
      .clock(clock), .wr_en(mem_wr), .wr_addr(col_ff), .wr_data(g_ff),
      .rd_addr(col_ff), .rd_data(above_rd)
   );

   lvs_ram #(.WIDTH(GrayBits), .DEPTH(MaxWidth)) u_two_above (
      .clock(clock), .wr_en(mem_wr), .wr_addr(col_ff), .wr_data(above_rd),
      .rd_addr(col_ff), .rd_data(two_rd)
   );

   lvs_var_unit u_var (
      .clock(clock), .reset(reset), .start(unit_start), .frame(frame_in),
      .ready(unit_ready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= P_IDLE;
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
         col_ff    <= '0;
         row_ff    <= '0;
         sum_ff    <= '0;
         sqsum_ff  <= '0;
         count_ff  <= '0;
         for (int i = 0; i < 6; i++) w_ff[i] <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CsrWidth) width_ff <= clamp_dim(csr_wr_data, WidthMax);
            else height_ff <= clamp_dim(csr_wr_data, HeightMax);
         end
         case (state_ff)
            P_IDLE: if (req_tvalid) begin
               g_ff     <= g_in;
               state_ff <= P_READ;
            end
            P_READ: begin
               w_ff[0]  <= w_ff[1];
               w_ff[1]  <= w_ff[2];
               w_ff[2]  <= above_rd;
               w_ff[3]  <= w_ff[4];
               w_ff[4]  <= two_rd;
               w_ff[5]  <= g_ff;
               lap_ff   <= lap_in;
               inner_ff <= (col_ff >= ColBits'(2)) && (row_ff >= ColBits'(2));
               state_ff <= P_SQ;
            end
            P_SQ: begin
               sq_ff    <= sq_full[SqBits-1:0];
               state_ff <= P_ACC;
            end
            P_ACC: begin
               if (!frame_end) begin
                  sum_ff   <= frame_in.sum;
                  sqsum_ff <= frame_in.sq_sum;
                  count_ff <= frame_in.count;
                  if (row_end) begin
                     col_ff <= '0;
                     row_ff <= row_ff + ColBits'(1);
                  end else begin
                     col_ff <= col_ff + ColBits'(1);
                  end
                  state_ff <= P_IDLE;
               end else if (unit_ready) begin
                  sum_ff   <= '0;
                  sqsum_ff <= '0;
                  count_ff <= '0;
                  col_ff   <= '0;
                  row_ff   <= '0;
                  state_ff <= P_IDLE;
               end
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end
endmodule
